FILE: design/qrs_pkg.sv
// qrs_pkg: shared widths, codes and types of the quadratic root solver
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int TOL_BITS  = 16;
    localparam int CNT_BITS  = 2;

    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd33;

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int D_BITS    = 2 * WORD_BITS + 3;
    localparam int RAD_BITS  = 2 * WORD_BITS + 2;
    localparam int ROOT_BITS = WORD_BITS + 1;
    localparam int SQRT_STG  = ROOT_BITS;
    localparam int SREM_BITS = ROOT_BITS + 2;

    localparam int NUM_BITS  = WORD_BITS + 3;
    localparam int NMAG_BITS = WORD_BITS + 2;
    localparam int DEN_BITS  = WORD_BITS + 1;
    localparam int QUO_BITS  = WORD_BITS + 1;
    localparam int DREM_BITS = DEN_BITS + 1;
    localparam int NSH_BITS  = NMAG_BITS + FRAC_BITS;
    localparam int DIV_STG   = QUO_BITS;
    localparam int DIV_LAT   = DIV_STG + 2;

    localparam int FRONT_STG = 5;
    localparam int MID_STG   = 2;
    localparam int LAT       = FRONT_STG + SQRT_STG + MID_STG + DIV_LAT;

    localparam logic [CNT_BITS-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_BITS-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_BITS-1:0] CNT_TWO  = 2'd2;
    localparam logic [CNT_BITS-1:0] CNT_INF  = 2'd3;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_INF   = 3'd1,
        K_LIN   = 3'd2,
        K_CZERO = 3'd3,
        K_DBL   = 3'd4,
        K_TWO   = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [WORD_BITS:0]   negb;
        logic [WORD_BITS:0]   negc;
        logic [DEN_BITS-1:0]  den;
        logic                 dneg;
    } t_side;

    function automatic logic [CNT_BITS-1:0] kind_count(input t_kind k);
        logic [CNT_BITS-1:0] c;
        case (k)
            K_INF:   c = CNT_INF;
            K_LIN:   c = CNT_ONE;
            K_DBL:   c = CNT_ONE;
            K_CZERO: c = CNT_TWO;
            K_TWO:   c = CNT_TWO;
            default: c = CNT_NONE;
        endcase
        return c;
    endfunction

endpackage

FILE: design/qrs_coef_if.sv
// qrs_coef_if: coefficient channel, valid/ready with a, b, c payload
// depends on qrs_pkg
`timescale 1ns / 1ps

interface qrs_coef_if;
    import qrs_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] coef_square;
    logic signed [WORD_BITS-1:0] coef_linear;
    logic signed [WORD_BITS-1:0] coef_const;

    modport source(output valid, output coef_square, output coef_linear, output coef_const,
                   input ready);
    modport sink(input valid, input coef_square, input coef_linear, input coef_const,
                 output ready);
endinterface

FILE: design/qrs_root_if.sv
// qrs_root_if: result channel, valid/ready with count, roots and overflow
// depends on qrs_pkg
`timescale 1ns / 1ps

interface qrs_root_if;
    import qrs_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [CNT_BITS-1:0]         root_count;
    logic signed [WORD_BITS-1:0] root_one;
    logic signed [WORD_BITS-1:0] root_two;
    logic                        overflow;

    modport source(output valid, output root_count, output root_one, output root_two,
                   output overflow, input ready);
    modport sink(input valid, input root_count, input root_one, input root_two,
                 input overflow, output ready);
endinterface

FILE: design/qrs_cfg_if.sv
// qrs_cfg_if: configuration write channel for the zero tolerance register
// depends on qrs_pkg
`timescale 1ns / 1ps

interface qrs_cfg_if;
    import qrs_pkg::*;
    logic                valid;
    logic                ready;
    logic [TOL_BITS-1:0] zero_tolerance;

    modport source(output valid, output zero_tolerance, input ready);
    modport sink(input valid, input zero_tolerance, output ready);
endinterface

FILE: design/qrs_sqrt.sv
// qrs_sqrt: pipelined integer square root, one root bit per stage
// depends on qrs_pkg; carries a t_side record alongside the radicand
`timescale 1ns / 1ps

module qrs_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [qrs_pkg::RAD_BITS-1:0]   i_rad,
    input  qrs_pkg::t_side                 i_side,
    output logic [qrs_pkg::ROOT_BITS-1:0]  o_root,
    output qrs_pkg::t_side                 o_side
);
    import qrs_pkg::*;

    logic [SREM_BITS-1:0] r_rem  [0:SQRT_STG-1];
    logic [ROOT_BITS-1:0] r_root [0:SQRT_STG-1];
    logic [RAD_BITS-1:0]  r_rad  [0:SQRT_STG-1];
    t_side                r_side [0:SQRT_STG-1];

    genvar k;
    for (k = 0; k < SQRT_STG; k++) begin : g_stg
        logic [SREM_BITS-1:0] p_rem;
        logic [ROOT_BITS-1:0] p_root;
        logic [RAD_BITS-1:0]  p_rad;
        t_side                p_side;
        logic [SREM_BITS+1:0] n_cat;
        logic [SREM_BITS+1:0] n_trial;
        logic                 n_take;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_side = r_side[k-1];
        end

        // bring down the next radicand bit pair, try root*4+1
        assign n_cat   = {p_rem, p_rad[2*(SQRT_STG-1-k)+1 -: 2]};
        assign n_trial = {SREM_BITS'(p_root), 2'b01};
        assign n_take  = (n_cat >= n_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_take ? SREM_BITS'(n_cat - n_trial) : SREM_BITS'(n_cat);
                r_root[k] <= {p_root[ROOT_BITS-2:0], n_take};
                r_rad[k]  <= p_rad;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_root = r_root[SQRT_STG-1];
    assign o_side = r_side[SQRT_STG-1];

endmodule

FILE: design/qrs_div.sv
// qrs_div: pipelined fixed point divider, restoring, one quotient bit per stage
// depends on qrs_pkg; gives the truncated signed quotient saturated to a word
`timescale 1ns / 1ps

module qrs_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [qrs_pkg::NMAG_BITS-1:0]       i_nmag,
    input  logic                                i_nneg,
    input  logic [qrs_pkg::DEN_BITS-1:0]        i_den,
    input  logic                                i_dneg,
    output logic signed [qrs_pkg::WORD_BITS-1:0] o_quo,
    output logic                                o_ovf
);
    import qrs_pkg::*;

    logic [NSH_BITS-1:0]  r_num [0:DIV_STG];
    logic [DREM_BITS-1:0] r_rem [0:DIV_STG];
    logic [QUO_BITS-1:0]  r_quo [0:DIV_STG];
    logic [DEN_BITS-1:0]  r_den [0:DIV_STG];
    logic                 r_neg [0:DIV_STG];
    logic                 r_pre [0:DIV_STG];
    logic [WORD_BITS-1:0] r_res;
    logic                 r_ovf;

    logic [NSH_BITS-1:0]  n_num;
    logic [QUO_BITS-1:0]  n_lim;
    logic                 n_sat;
    logic [QUO_BITS-1:0]  n_mag;

    // quotient wider than QUO_BITS is caught up front and saturates
    assign n_num = {i_nmag, FRAC_BITS'(0)};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= n_num;
            r_rem[0] <= DREM_BITS'(n_num >> QUO_BITS);
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_nneg ^ i_dneg;
            r_pre[0] <= ((DEN_BITS + QUO_BITS)'(n_num) >= {i_den, QUO_BITS'(0)});
        end
    end

    genvar k;
    for (k = 1; k <= DIV_STG; k++) begin : g_stg
        logic [DREM_BITS-1:0] n_cat;
        logic                 n_take;

        assign n_cat  = {r_rem[k-1][DREM_BITS-2:0], r_num[k-1][QUO_BITS-k]};
        assign n_take = (n_cat >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_take ? (n_cat - {1'b0, r_den[k-1]}) : n_cat;
                r_quo[k] <= {r_quo[k-1][QUO_BITS-2:0], n_take};
                r_num[k] <= r_num[k-1];
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_pre[k] <= r_pre[k-1];
            end
        end
    end

    always_comb begin
        n_lim = QUO_BITS'(1) << (WORD_BITS - 1);
        if (!r_neg[DIV_STG]) begin
            n_lim = n_lim - QUO_BITS'(1);
        end
        n_sat = r_pre[DIV_STG] || (r_quo[DIV_STG] > n_lim);
        n_mag = n_sat ? n_lim : r_quo[DIV_STG];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= r_neg[DIV_STG] ? WORD_BITS'(QUO_BITS'(0) - n_mag) : WORD_BITS'(n_mag);
            r_ovf <= n_sat;
        end
    end

    assign o_quo = r_res;
    assign o_ovf = r_ovf;

endmodule

FILE: design/quadratic_root_solver_unit.sv
// quadratic_root_solver_unit: top level, real roots of a*x^2+b*x+c in Q16.16
// depends on qrs_pkg, qrs_coef_if, qrs_root_if, qrs_cfg_if, qrs_sqrt, qrs_div
`timescale 1ns / 1ps

// Fully pipelined: one coefficient transfer is accepted every cycle unless the output
// stalls, and each result leaves at the end of 75 register stages (5 front stages for
// magnitudes, products, discriminant and case selection, 33 square root stages, 2
// numerator stages and 35 divider stages). When the result is not taken the whole
// pipeline holds, so ready drops only while a finished result waits. The zero
// tolerance register resets to 33 and accepts every write; the user must write it
// only while no item is in flight, the block itself does not enforce this.
module quadratic_root_solver_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qrs_coef_if.sink     i_coef,
    qrs_root_if.source   o_root,
    qrs_cfg_if.sink      i_cfg
);
    import qrs_pkg::*;

    logic                  w_en;
    logic [LAT-1:0]        r_vld;
    logic [TOL_BITS-1:0]   r_tol;

    logic [WORD_BITS-1:0]  r0_a, r0_b, r0_c;

    logic [WORD_BITS-1:0]  r1_am, r1_bm, r1_cm;
    logic                  r1_an, r1_bn, r1_cn;
    logic [WORD_BITS:0]    r1_negb, r1_negc;

    logic [PROD_BITS-1:0]  r2_b2, r2_ac;
    logic [WORD_BITS-1:0]  r2_am, r2_bm;
    logic                  r2_an, r2_bn, r2_cn;
    logic                  r2_az, r2_bz, r2_cz;
    logic [WORD_BITS:0]    r2_negb, r2_negc;

    logic [D_BITS-1:0]     r3_d;
    logic [WORD_BITS-1:0]  r3_am, r3_bm;
    logic                  r3_an, r3_bn;
    logic                  r3_az, r3_bz, r3_cz;
    logic [WORD_BITS:0]    r3_negb, r3_negc;

    logic signed [D_BITS-1:0] w_d, w_tol;
    t_side                 n4_side;
    logic [RAD_BITS-1:0]   n4_rad;
    t_side                 r4_side;
    logic [RAD_BITS-1:0]   r4_rad;

    logic [ROOT_BITS-1:0]  w_s;
    t_side                 w_side;

    logic [NUM_BITS-1:0]   w_mb, w_mc, w_sx;
    logic [NUM_BITS-1:0]   n5_num1, n5_num2;
    logic [NUM_BITS-1:0]   r5_num1, r5_num2;
    logic [DEN_BITS-1:0]   r5_den;
    logic                  r5_dneg;
    t_kind                 r5_kind;

    logic [NMAG_BITS-1:0]  r6_n1mag, r6_n2mag;
    logic                  r6_n1neg, r6_n2neg;
    logic [DEN_BITS-1:0]   r6_den;
    logic                  r6_dneg;
    t_kind                 r6_kind;

    t_kind                 r_kindq [0:DIV_LAT-1];

    logic signed [WORD_BITS-1:0] w_q1, w_q2;
    logic                  w_o1, w_o2;

    assign w_en         = !r_vld[LAT-1] || o_root.ready;
    assign i_coef.ready = w_en;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_tol <= TOL_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_tol <= i_cfg.zero_tolerance;
            end
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], i_coef.valid};
            end
        end
    end

    // front: capture, magnitudes, products and tolerance tests, discriminant, registered case selection
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_a <= i_coef.coef_square;
            r0_b <= i_coef.coef_linear;
            r0_c <= i_coef.coef_const;

            r1_an   <= r0_a[WORD_BITS-1];
            r1_bn   <= r0_b[WORD_BITS-1];
            r1_cn   <= r0_c[WORD_BITS-1];
            r1_am   <= r0_a[WORD_BITS-1] ? (WORD_BITS'(0) - r0_a) : r0_a;
            r1_bm   <= r0_b[WORD_BITS-1] ? (WORD_BITS'(0) - r0_b) : r0_b;
            r1_cm   <= r0_c[WORD_BITS-1] ? (WORD_BITS'(0) - r0_c) : r0_c;
            r1_negb <= (WORD_BITS + 1)'(0) - {r0_b[WORD_BITS-1], r0_b};
            r1_negc <= (WORD_BITS + 1)'(0) - {r0_c[WORD_BITS-1], r0_c};

            r2_b2   <= PROD_BITS'(r1_bm) * PROD_BITS'(r1_bm);
            r2_ac   <= PROD_BITS'(r1_am) * PROD_BITS'(r1_cm);
            r2_az   <= (r1_am <= WORD_BITS'(r_tol));
            r2_bz   <= (r1_bm <= WORD_BITS'(r_tol));
            r2_cz   <= (r1_cm <= WORD_BITS'(r_tol));
            r2_am   <= r1_am;
            r2_bm   <= r1_bm;
            r2_an   <= r1_an;
            r2_bn   <= r1_bn;
            r2_cn   <= r1_cn;
            r2_negb <= r1_negb;
            r2_negc <= r1_negc;

            r3_d    <= (r2_an ^ r2_cn) ? (D_BITS'(r2_b2) + D_BITS'({r2_ac, 2'b00}))
                                       : (D_BITS'(r2_b2) - D_BITS'({r2_ac, 2'b00}));
            r3_az   <= r2_az;
            r3_bz   <= r2_bz;
            r3_cz   <= r2_cz;
            r3_am   <= r2_am;
            r3_bm   <= r2_bm;
            r3_an   <= r2_an;
            r3_bn   <= r2_bn;
            r3_negb <= r2_negb;
            r3_negc <= r2_negc;

            r4_side <= n4_side;
            r4_rad  <= n4_rad;
        end
    end

    assign w_d   = r3_d;
    assign w_tol = D_BITS'({r_tol, FRAC_BITS'(0)});

    always_comb begin
        n4_side.kind = K_NONE;
        n4_side.negb = r3_negb;
        n4_side.negc = r3_negc;
        n4_side.den  = DEN_BITS'(1);
        n4_side.dneg = 1'b0;
        n4_rad       = '0;
        if (r3_az) begin
            if (r3_bz) begin
                n4_side.kind = r3_cz ? K_INF : K_NONE;
            end else begin
                n4_side.kind = K_LIN;
                n4_side.den  = DEN_BITS'(r3_bm);
                n4_side.dneg = r3_bn;
            end
        end else if (r3_cz) begin
            n4_side.kind = K_CZERO;
            n4_side.den  = DEN_BITS'(r3_am);
            n4_side.dneg = r3_an;
        end else if ((w_d < 0) && (w_d <= -w_tol)) begin
            n4_side.kind = K_NONE;
        end else if (w_d <= w_tol) begin
            n4_side.kind = K_DBL;
            n4_side.den  = {r3_am, 1'b0};
            n4_side.dneg = r3_an;
        end else begin
            n4_side.kind = K_TWO;
            n4_side.den  = {r3_am, 1'b0};
            n4_side.dneg = r3_an;
            n4_rad       = RAD_BITS'(r3_d);
        end
    end

    qrs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r4_rad),
        .i_side (r4_side),
        .o_root (w_s),
        .o_side (w_side)
    );

    // numerators: -c, -b, -b+s, -b-s depending on the case
    assign w_mb = {{2{w_side.negb[WORD_BITS]}}, w_side.negb};
    assign w_mc = {{2{w_side.negc[WORD_BITS]}}, w_side.negc};
    assign w_sx = NUM_BITS'(w_s);

    always_comb begin
        n5_num1 = '0;
        n5_num2 = '0;
        case (w_side.kind)
            K_LIN:   n5_num1 = w_mc;
            K_CZERO: n5_num2 = w_mb;
            K_DBL:   n5_num1 = w_mb + w_sx;
            K_TWO: begin
                n5_num1 = w_mb + w_sx;
                n5_num2 = w_mb - w_sx;
            end
            default: begin
                n5_num1 = '0;
                n5_num2 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_num1 <= n5_num1;
            r5_num2 <= n5_num2;
            r5_den  <= w_side.den;
            r5_dneg <= w_side.dneg;
            r5_kind <= w_side.kind;

            r6_n1neg <= r5_num1[NUM_BITS-1];
            r6_n2neg <= r5_num2[NUM_BITS-1];
            r6_n1mag <= NMAG_BITS'(r5_num1[NUM_BITS-1] ? (NUM_BITS'(0) - r5_num1) : r5_num1);
            r6_n2mag <= NMAG_BITS'(r5_num2[NUM_BITS-1] ? (NUM_BITS'(0) - r5_num2) : r5_num2);
            r6_den   <= r5_den;
            r6_dneg  <= r5_dneg;
            r6_kind  <= r5_kind;
        end
    end

    qrs_div u_div1 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_nmag (r6_n1mag),
        .i_nneg (r6_n1neg),
        .i_den  (r6_den),
        .i_dneg (r6_dneg),
        .o_quo  (w_q1),
        .o_ovf  (w_o1)
    );

    qrs_div u_div2 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_nmag (r6_n2mag),
        .i_nneg (r6_n2neg),
        .i_den  (r6_den),
        .i_dneg (r6_dneg),
        .o_quo  (w_q2),
        .o_ovf  (w_o2)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kindq[0] <= r6_kind;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_kindq[i] <= r_kindq[i-1];
            end
        end
    end

    assign o_root.valid      = r_vld[LAT-1];
    assign o_root.root_count = kind_count(r_kindq[DIV_LAT-1]);
    assign o_root.root_one   = w_q1;
    assign o_root.root_two   = w_q2;
    assign o_root.overflow   = w_o1 | w_o2;

`ifndef SYNTH
    a_no_root_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_root.valid && (o_root.root_count == CNT_NONE || o_root.root_count == CNT_INF)
        |-> (o_root.root_one == '0) && (o_root.root_two == '0) && !o_root.overflow)
        else $error("no-root result carries a root value");

    a_one_root_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_root.valid && (o_root.root_count == CNT_ONE) |-> (o_root.root_two == '0))
        else $error("single root result has a second root");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_root.valid && !o_root.ready |-> !i_coef.ready)
        else $error("input taken while a result waits");

    a_transfer_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_coef.valid && i_coef.ready |=> r_vld[0])
        else $error("accepted transfer lost at pipeline entry");
`endif

endmodule

FILE: verif/quadratic_root_solver_unit_tb.sv
// quadratic_root_solver_unit_tb: self-checking bench for the quadratic root solver
// depends on qrs_pkg, qrs_coef_if, qrs_root_if, qrs_cfg_if and quadratic_root_solver_unit
`timescale 1ns / 1ps

module quadratic_root_solver_unit_tb;
    import qrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = LAT + 20;

    typedef struct packed {
        logic [CNT_BITS-1:0]         root_count;
        logic signed [WORD_BITS-1:0] root_one;
        logic signed [WORD_BITS-1:0] root_two;
        logic                        overflow;
    } t_roots;

    typedef struct {
        logic signed [WORD_BITS-1:0] a;
        logic signed [WORD_BITS-1:0] b;
        logic signed [WORD_BITS-1:0] c;
        bit                          typed;
        t_roots                      want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qrs_coef_if coef_bus();
    qrs_root_if root_bus();
    qrs_cfg_if  cfg_bus();

    quadratic_root_solver_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_coef (coef_bus.sink),
        .o_root (root_bus.source),
        .i_cfg  (cfg_bus.sink)
    );

    always #2 i_clk = ~i_clk;

    logic [TOL_BITS-1:0] tol_model = TOL_RESET;
    t_roots              pending_roots[$];
    int                  mismatch_count = 0;
    int                  idle_cycles = 0;
    int                  out_wait = 0;
    bit                  stim_done = 1'b0;

    function automatic logic [127:0] abs_wide(input logic signed [WORD_BITS-1:0] v);
        logic signed [127:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    // truncated (num << FRAC_BITS) / den with sign and saturation
    function automatic logic [WORD_BITS-1:0] fixed_quotient(input logic [127:0] nmag,
            input bit nneg, input logic [127:0] dmag, input bit dneg, inout bit ovf);
        logic [127:0] q;
        logic [127:0] limit;
        bit           neg;
        neg = (nneg != dneg);
        if (nmag == 0) return '0;
        if (dmag == 0) q = {128{1'b1}};
        else q = (nmag << FRAC_BITS) / dmag;
        limit = neg ? (128'd1 << (WORD_BITS - 1)) : ((128'd1 << (WORD_BITS - 1)) - 1);
        if (q > limit) begin
            ovf = 1'b1;
            q = limit;
        end
        return neg ? WORD_BITS'(-q) : WORD_BITS'(q);
    endfunction

    function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] t;
        r = 0;
        for (int k = 63; k >= 0; k--) begin
            t = r | (128'd1 << k);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic t_roots solve_roots(input logic signed [WORD_BITS-1:0] a,
            input logic signed [WORD_BITS-1:0] b, input logic signed [WORD_BITS-1:0] c,
            input logic [TOL_BITS-1:0] tol);
        t_roots              r;
        logic [127:0]        am, bm, cm, tw;
        logic signed [129:0] disc, sq, mb, n1, n2;
        bit                  ovf;
        am = abs_wide(a);
        bm = abs_wide(b);
        cm = abs_wide(c);
        ovf = 1'b0;
        r = '0;
        tw = 128'(tol) << FRAC_BITS;
        if (am <= tol) begin
            if (bm <= tol) r.root_count = (cm <= tol) ? CNT_INF : CNT_NONE;
            else begin
                r.root_one = fixed_quotient(cm, !c[WORD_BITS-1], bm, b[WORD_BITS-1], ovf);
                r.root_count = CNT_ONE;
            end
        end else if (cm <= tol) begin
            r.root_two = fixed_quotient(bm, !b[WORD_BITS-1], am, a[WORD_BITS-1], ovf);
            r.root_count = CNT_TWO;
        end else begin
            disc = $signed(130'(bm * bm)) - 4 * $signed(130'(a)) * $signed(130'(c));
            if (disc < 0 && -disc >= $signed(130'(tw))) r.root_count = CNT_NONE;
            else if ((disc < 0 ? -disc : disc) <= $signed(130'(tw))) begin
                r.root_one = fixed_quotient(bm, !b[WORD_BITS-1], am << 1,
                                            a[WORD_BITS-1], ovf);
                r.root_count = CNT_ONE;
            end else begin
                sq = $signed(130'(floor_sqrt(128'(disc))));
                mb = -$signed(130'(b));
                n1 = mb + sq;
                n2 = mb - sq;
                r.root_one = fixed_quotient(128'(n1 < 0 ? -n1 : n1), n1 < 0, am << 1,
                                            a[WORD_BITS-1], ovf);
                r.root_two = fixed_quotient(128'(n2 < 0 ? -n2 : n2), n2 < 0, am << 1,
                                            a[WORD_BITS-1], ovf);
                r.root_count = CNT_TWO;
            end
        end
        r.overflow = ovf;
        return r;
    endfunction

    // valid stays up into the next transfer when no gap is drawn
    task automatic send_coefs(input logic signed [WORD_BITS-1:0] a,
            input logic signed [WORD_BITS-1:0] b, input logic signed [WORD_BITS-1:0] c);
        int gap;
        coef_bus.valid <= 1'b1;
        coef_bus.coef_square <= a;
        coef_bus.coef_linear <= b;
        coef_bus.coef_const <= c;
        do @(posedge i_clk); while (!coef_bus.ready);
        pending_roots.push_back(solve_roots(a, b, c, tol_model));
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            coef_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic stop_coefs();
        coef_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_BITS-1:0] value);
        stop_coefs();
        wait (pending_roots.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.zero_tolerance <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        tol_model = value;
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic signed [WORD_BITS-1:0] random_coef();
        case ($urandom_range(0, 5))
            0: return WORD_BITS'($signed($urandom_range(0, 80)) - 40);
            1: return WORD_BITS'($signed($urandom_range(0, 20)) - 10) <<< FRAC_BITS;
            2: return ($urandom_range(0, 1) ? 1 : -1) * (32'sd1 <<< $urandom_range(0, 30));
            default: return $urandom;
        endcase
    endfunction

    // consumer, holds ready low for a random wait, possibly none, after each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            root_bus.ready <= 1'b0;
            out_wait = 0;
        end else begin
            if (root_bus.valid && root_bus.ready) begin
                if (pending_roots.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected transfer: count %0d", root_bus.root_count);
                end else begin
                    t_roots want;
                    want = pending_roots.pop_front();
                    if (want.root_count !== root_bus.root_count ||
                        want.root_one !== root_bus.root_one ||
                        want.root_two !== root_bus.root_two ||
                        want.overflow !== root_bus.overflow) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     want.root_count, want.root_one, want.root_two,
                                     want.overflow, root_bus.root_count,
                                     root_bus.root_one, root_bus.root_two,
                                     root_bus.overflow);
                    end
                end
                out_wait = $urandom_range(0, 4);
            end
            root_bus.ready <= (out_wait == 0);
            if (out_wait > 0) out_wait = out_wait - 1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((coef_bus.valid && coef_bus.ready) || (root_bus.valid && root_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    localparam logic signed [WORD_BITS-1:0] MAXW = 32'sh7fffffff;
    localparam logic signed [WORD_BITS-1:0] MINW = 32'sh80000000;
    localparam logic signed [WORD_BITS-1:0] ONE  = 32'sh00010000;

    t_row directed[] = '{
        '{0, 0, 0, 1, '{CNT_INF, 0, 0, 0}},
        '{0, 0, ONE, 1, '{CNT_NONE, 0, 0, 0}},
        '{33, -33, 33, 1, '{CNT_INF, 0, 0, 0}},
        '{34, 0, 0, 0, '{0, 0, 0, 0}},
        '{0, ONE, -2 * ONE, 0, '{0, 0, 0, 0}},
        '{0, 34, MAXW, 0, '{0, 0, 0, 0}},
        '{0, -34, MINW, 0, '{0, 0, 0, 0}},
        '{ONE, 3 * ONE, 0, 0, '{0, 0, 0, 0}},
        '{34, MAXW, 5, 0, '{0, 0, 0, 0}},
        '{ONE, 2 * ONE, ONE, 0, '{0, 0, 0, 0}},
        '{ONE, 0, ONE, 1, '{CNT_NONE, 0, 0, 0}},
        '{ONE, -3 * ONE, 2 * ONE, 0, '{0, 0, 0, 0}},
        '{-ONE, ONE, 6 * ONE, 0, '{0, 0, 0, 0}},
        '{MAXW, MAXW, MAXW, 0, '{0, 0, 0, 0}},
        '{MINW, MINW, MINW, 0, '{0, 0, 0, 0}},
        '{MINW, MAXW, MAXW, 0, '{0, 0, 0, 0}},
        '{34, MINW, 34, 0, '{0, 0, 0, 0}},
        '{-34, MAXW, -34, 0, '{0, 0, 0, 0}},
        '{MAXW, 0, MINW, 0, '{0, 0, 0, 0}},
        '{ONE, 256, 1, 0, '{0, 0, 0, 0}}
    };

    initial begin
        coef_bus.valid = 1'b0;
        coef_bus.coef_square = '0;
        coef_bus.coef_linear = '0;
        coef_bus.coef_const = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.zero_tolerance = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) begin
            if (directed[k].typed) begin
                send_coefs(directed[k].a, directed[k].b, directed[k].c);
                pending_roots[pending_roots.size()-1] = directed[k].want;
            end else send_coefs(directed[k].a, directed[k].b, directed[k].c);
        end
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: write_tolerance('0);
                2: write_tolerance(16'hffff);
                3: write_tolerance(TOL_BITS'($urandom_range(1, 65534)));
                4: write_tolerance(TOL_RESET);
                default: ;
            endcase
            for (int n = 0; n < 130; n++) begin
                logic signed [WORD_BITS-1:0] a, b, c;
                int s;
                a = random_coef();
                b = random_coef();
                c = random_coef();
                // favor real double roots: b = -2*s*a, c = s*s*a
                if ($urandom_range(0, 5) == 0) begin
                    s = $signed($urandom_range(0, 16)) - 8;
                    a = WORD_BITS'($signed($urandom_range(0, 64)) - 32) <<< FRAC_BITS;
                    b = -2 * s * a;
                    c = s * s * a;
                end
                if (n == 60) begin
                    stop_coefs();
                    wait (pending_roots.size() == 0);
                end
                send_coefs(a, b, c);
            end
        end
        stop_coefs();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        wait (pending_roots.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_roots.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/qrs_pkg.sv
design/qrs_coef_if.sv
design/qrs_root_if.sv
design/qrs_cfg_if.sv
design/qrs_sqrt.sv
design/qrs_div.sv
design/quadratic_root_solver_unit.sv
verif/quadratic_root_solver_unit_tb.sv
